// File: sv/aligned_page_allocator_assert.svh
// Assertion macros for the aligned page allocator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ALIGNED_PAGE_ALLOCATOR_ASSERT_SVH
`define ALIGNED_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define APA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aligned page allocator check failed");

// Next-cycle implication, disabled during reset.
`define APA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aligned page allocator check failed");

`endif

// File: sv/apa_pkg.sv
// Shared types and constants of the aligned page allocator.
// No dependencies; used by the controller, the datapath and the top level.
package apa_pkg;

    localparam int OWNER_W     = 6;
    localparam int BYTES_W     = 25;
    localparam int PAGES_CFG_W = 14;
    localparam int CFG_W       = 25;

    localparam logic CFG_PAGES_IN_USE = 1'b0;
    localparam logic CFG_MAX_REQUEST  = 1'b1;

    localparam logic [PAGES_CFG_W-1:0] PAGES_RESET   = 14'd8192;
    localparam logic [BYTES_W-1:0]     MAX_REQ_RESET = 25'd16777216;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_CAND,
        ST_READ,
        ST_CHECK,
        ST_WRITE,
        ST_FREE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_OK,
        RES_FREE
    } res_t;

    typedef struct packed {
        logic load;
        logic align_dbl;
        logic cand_init;
        logic p_first;
        logic rd;
        logic page_inc;
        logic skip;
        logic wr_owner;
        logic clear_wr;
        logic sweep_rd;
        logic res_set;
        res_t res_sel;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic op_free;
        logic owner_bad;
        logic bad_req;
        logic align_lt;
        logic fits;
        logic page_busy;
        logic at_last;
        logic at_end;
    } status_t;

endpackage

// File: sv/apa_req_if.sv
// Request channel of the aligned page allocator.
// Depends on apa_pkg for field widths.
interface apa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [apa_pkg::OWNER_W-1:0] owner_id;
    logic [apa_pkg::BYTES_W-1:0] request_bytes;

    modport source (output valid, output operation, output owner_id,
                    output request_bytes, input ready);
    modport sink (input valid, input operation, input owner_id,
                  input request_bytes, output ready);
endinterface

// File: sv/apa_rsp_if.sv
// Result channel of the aligned page allocator.
// Depends on apa_pkg for field widths.
interface apa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [apa_pkg::BYTES_W-1:0] start_address;

    modport source (output valid, output ok, output start_address, input ready);
    modport sink (input valid, input ok, input start_address, output ready);
endinterface

// File: sv/apa_datapath.sv
// Datapath: configuration, request registers, page ownership memory, address math.
// Depends on apa_pkg; driven by apa_ctrl through cmd_t and reports status_t.
module apa_datapath #(
    parameter int PAGE_BYTES     = 4096,
    parameter int MAX_PAGE_COUNT = 8192,
    parameter int OWNER_COUNT    = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [apa_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        operation,
    input  logic [apa_pkg::OWNER_W-1:0] owner_id,
    input  logic [apa_pkg::BYTES_W-1:0] request_bytes,
    input  apa_pkg::cmd_t               cmd,
    output apa_pkg::status_t            st,
    output logic                        ok,
    output logic [apa_pkg::BYTES_W-1:0] start_address
);
    import apa_pkg::*;

    localparam int PBL = $clog2(PAGE_BYTES);
    localparam int PW  = (MAX_PAGE_COUNT > 1) ? $clog2(MAX_PAGE_COUNT) : 1;
    localparam int OW  = $clog2(OWNER_COUNT + 1);
    localparam int SW  = ((PW + PBL) > (BYTES_W + 1) ? (PW + PBL) : (BYTES_W + 1)) + 2;

    logic [PAGES_CFG_W-1:0] pages_reg;
    logic [BYTES_W-1:0]     max_req_reg;

    logic               op_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [BYTES_W-1:0] size_reg;
    logic [SW-1:0]      align_reg;
    logic [SW-1:0]      s_reg;
    logic [PW-1:0]      p_reg;
    logic [OW-1:0]      rd_data_reg;
    logic               sv_valid_reg;
    logic [PW-1:0]      sv_addr_reg;
    logic               pend_ok_reg;
    logic [BYTES_W-1:0] pend_addr_reg;
    logic               ok_reg;
    logic [BYTES_W-1:0] addr_reg;

    logic [OW-1:0] mem [MAX_PAGE_COUNT];

    logic [OW-1:0] tag;
    logic [SW-1:0] size_ext;
    logic [SW-1:0] active_ext;
    logic [SW-1:0] total;
    logic [SW-1:0] s_end;
    logic [SW-1:0] s_last;
    logic [PW-1:0] first_pg;
    logic [PW-1:0] last_pg;
    logic [SW-1:0] beyond;
    logic [SW-1:0] rounded;
    logic [SW-1:0] s_plus_align;
    logic [SW-1:0] skip_next;
    logic          we;
    logic [PW-1:0] wa;
    logic [OW-1:0] wd;

    assign tag          = OW'(owner_reg) + OW'(1);
    assign size_ext     = SW'(size_reg);
    assign active_ext   = (SW'(pages_reg) > SW'(MAX_PAGE_COUNT)) ? SW'(MAX_PAGE_COUNT)
                                                                 : SW'(pages_reg);
    assign total        = active_ext << PBL;
    assign s_end        = s_reg + size_ext;
    assign s_last       = s_end - SW'(1);
    assign first_pg     = s_reg[PBL +: PW];
    assign last_pg      = s_last[PBL +: PW];
    assign beyond       = (SW'(p_reg) + SW'(1)) << PBL;
    // Round the end of the busy page up to the next aligned start.
    assign rounded      = (beyond + align_reg - SW'(1)) & ~(align_reg - SW'(1));
    assign s_plus_align = s_reg + align_reg;
    assign skip_next    = (rounded < s_plus_align) ? s_plus_align : rounded;

    assign st.op_free   = op_reg;
    assign st.owner_bad = 32'(owner_reg) >= OWNER_COUNT;
    assign st.bad_req   = (size_reg == '0) || (size_reg > max_req_reg) || st.owner_bad;
    assign st.align_lt  = align_reg < size_ext;
    assign st.fits      = s_end <= total;
    assign st.page_busy = rd_data_reg != '0;
    assign st.at_last   = p_reg == last_pg;
    assign st.at_end    = p_reg == PW'(MAX_PAGE_COUNT - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg   <= PAGES_RESET;
            max_req_reg <= MAX_REQ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAGES_IN_USE: pages_reg   <= cfg_data[PAGES_CFG_W-1:0];
                CFG_MAX_REQUEST:  max_req_reg <= cfg_data[BYTES_W-1:0];
                default:          pages_reg   <= pages_reg;
            endcase
        end
    end

    // The page counter starts at zero for the clearing pass after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg        <= '0;
            sv_valid_reg <= 1'b0;
        end
        else
        begin
            sv_valid_reg <= cmd.sweep_rd;
            if (cmd.load)
                p_reg <= '0;
            else if (cmd.p_first)
                p_reg <= first_pg;
            else if (cmd.page_inc || cmd.clear_wr || cmd.sweep_rd)
                p_reg <= (p_reg == PW'(MAX_PAGE_COUNT - 1)) ? '0 : p_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        sv_addr_reg <= p_reg;
        if (cmd.load)
        begin
            op_reg    <= operation;
            owner_reg <= owner_id;
            size_reg  <= request_bytes;
            align_reg <= SW'(1);
        end
        else if (cmd.align_dbl)
            align_reg <= align_reg << 1;
        if (cmd.cand_init)
            s_reg <= align_reg;
        else if (cmd.skip)
            s_reg <= skip_next;
        if (cmd.res_set)
        begin
            case (cmd.res_sel)
                RES_OK:
                begin
                    pend_ok_reg   <= 1'b1;
                    pend_addr_reg <= s_reg[BYTES_W-1:0];
                end
                RES_FREE:
                begin
                    pend_ok_reg   <= 1'b1;
                    pend_addr_reg <= '0;
                end
                default:
                begin
                    pend_ok_reg   <= 1'b0;
                    pend_addr_reg <= '0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            ok_reg   <= pend_ok_reg;
            addr_reg <= pend_addr_reg;
        end
    end

    always_comb
    begin
        we = 1'b0;
        wa = p_reg;
        wd = '0;
        if (cmd.clear_wr)
            we = 1'b1;
        else if (cmd.wr_owner)
        begin
            we = 1'b1;
            wd = tag;
        end
        else if (sv_valid_reg && rd_data_reg == tag)
        begin
            we = 1'b1;
            wa = sv_addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (cmd.rd || cmd.sweep_rd)
            rd_data_reg <= mem[p_reg];
    end

    assign ok            = ok_reg;
    assign start_address = addr_reg;
endmodule

// File: sv/apa_ctrl.sv
// Controller state machine of the aligned page allocator.
// Depends on apa_pkg; sequences apa_datapath through cmd_t.
module apa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_ready,
    output logic             out_valid,
    input  apa_pkg::status_t st,
    output apa_pkg::cmd_t    cmd
);
    import apa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_FAIL;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.at_end)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (st.op_free)
                begin
                    if (st.owner_bad)
                    begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_FREE;
                        state_next  = ST_DONE;
                    end
                    else
                        state_next = ST_FREE;
                end
                else if (st.bad_req)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (st.align_lt)
                    cmd.align_dbl = 1'b1;
                else
                begin
                    cmd.cand_init = 1'b1;
                    state_next    = ST_CAND;
                end
            end
            ST_CAND:
            begin
                if (st.fits)
                begin
                    cmd.p_first = 1'b1;
                    state_next  = ST_READ;
                end
                else
                begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (st.page_busy)
                begin
                    cmd.skip   = 1'b1;
                    state_next = ST_CAND;
                end
                else if (st.at_last)
                begin
                    // Every covered page is free: go back and claim them.
                    cmd.p_first = 1'b1;
                    state_next  = ST_WRITE;
                end
                else
                begin
                    cmd.page_inc = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_owner = 1'b1;
                if (st.at_last)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_OK;
                    state_next  = ST_DONE;
                end
                else
                    cmd.page_inc = 1'b1;
            end
            ST_FREE:
            begin
                cmd.sweep_rd = 1'b1;
                if (st.at_end)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                cmd.res_set = 1'b1;
                cmd.res_sel = RES_FREE;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;
endmodule

// File: sv/aligned_page_allocator.sv
// Aligned first-fit page allocator. After reset the ownership memory is cleared
// page by page before the first item is taken. An allocate doubles its alignment up
// to the size, then probes candidate starts page by page and claims the pages of the
// first free one; a rejected item goes straight to its result and a free of a valid
// owner sweeps the memory at one page a cycle. One read and one write of the
// ownership memory a cycle set the rate; one item is in work at a time.
module aligned_page_allocator #(
    parameter int PAGE_BYTES     = 4096,
    parameter int MAX_PAGE_COUNT = 8192,
    parameter int OWNER_COUNT    = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [apa_pkg::CFG_W-1:0] cfg_data,
    apa_req_if.sink                   req,
    apa_rsp_if.source                 rsp
);
    import apa_pkg::*;

    cmd_t    cmd;
    status_t st;

    apa_datapath #(
        .PAGE_BYTES     (PAGE_BYTES),
        .MAX_PAGE_COUNT (MAX_PAGE_COUNT),
        .OWNER_COUNT    (OWNER_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (req.operation),
        .owner_id      (req.owner_id),
        .request_bytes (req.request_bytes),
        .cmd           (cmd),
        .st            (st),
        .ok            (rsp.ok),
        .start_address (rsp.start_address)
    );

    apa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .st        (st),
        .cmd       (cmd)
    );

`include "aligned_page_allocator_assert.svh"

    `APA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    `APA_ASSERT_NOW(a_claim_in_bounds, cmd.wr_owner, st.fits && !st.bad_req)
    `APA_ASSERT_NOW(a_fail_has_zero_address, rsp.valid && !rsp.ok, rsp.start_address == '0)
endmodule

// File: test/aligned_page_allocator_tb.sv
// Testbench for the aligned page allocator: directed and random allocate and
// free items, checked against a page table kept in the bench.
// Depends on apa_pkg, apa_req_if, apa_rsp_if and aligned_page_allocator.
module aligned_page_allocator_tb;
    import apa_pkg::*;

    localparam int          PAGE_LEN    = 4096;
    localparam int          PAGE_TOTAL  = 8192;
    localparam logic        OP_ALLOC    = 1'b0;
    localparam logic        OP_FREE     = 1'b1;
    localparam longint      CYCLE_LIMIT = 20000000;

    typedef struct {
        logic               ok;
        logic [BYTES_W-1:0] start_address;
    } grant_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    apa_req_if req_ch ();
    apa_rsp_if rsp_ch ();

    aligned_page_allocator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    // Bench copy of the block state.
    logic [6:0]             owner_table [PAGE_TOTAL];
    logic [PAGES_CFG_W-1:0] pages_cfg;
    logic [BYTES_W-1:0]     max_bytes_cfg;

    grant_t grants_pending[$];
    int     error_count;
    longint cycle_count;
    bit     calm;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 38);
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // Works out the granted start of an allocate and claims its pages.
    task automatic first_fit(input logic [OWNER_W-1:0] owner, input longint unsigned size,
                             output longint unsigned start);
        longint unsigned align;
        longint unsigned total;
        longint unsigned s;
        longint unsigned first;
        longint unsigned last;
        longint unsigned p;
        longint unsigned beyond;
        longint unsigned nxt;
        bit              clash;
        align = 1;
        total = ((pages_cfg > PAGE_TOTAL) ? PAGE_TOTAL : pages_cfg) * PAGE_LEN;
        start = 0;
        if (size == 0 || size > max_bytes_cfg)
            return;
        while (align < size)
            align = align << 1;
        s = align;
        while (s + size <= total)
        begin
            first = s / PAGE_LEN;
            last  = (s + size - 1) / PAGE_LEN;
            clash = 0;
            for (p = first; p <= last; p++)
                if (owner_table[p] != 0)
                begin
                    clash = 1;
                    break;
                end
            if (!clash)
            begin
                for (p = first; p <= last; p++)
                    owner_table[p] = 7'(owner) + 7'd1;
                start = s;
                return;
            end
            // Jump past every candidate that still covers the busy page.
            beyond = (p + 1) * PAGE_LEN;
            nxt = ((beyond + align - 1) / align) * align;
            if (nxt < s + align)
                nxt = s + align;
            s = nxt;
        end
    endtask

    task automatic predict_grant(input logic op, input logic [OWNER_W-1:0] owner,
                                 input logic [BYTES_W-1:0] bytes);
        grant_t          g;
        longint unsigned start;
        if (op == OP_FREE)
        begin
            for (int p = 0; p < PAGE_TOTAL; p++)
                if (owner_table[p] == 7'(owner) + 7'd1)
                    owner_table[p] = 0;
            g.ok = 1'b1;
            g.start_address = '0;
        end
        else
        begin
            first_fit(owner, bytes, start);
            g.ok = (start != 0);
            g.start_address = start[BYTES_W-1:0];
        end
        grants_pending = {grants_pending, g};
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input logic op, input logic [OWNER_W-1:0] owner,
                             input logic [BYTES_W-1:0] bytes);
        bit taken;
        if (idle_now())
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while (idle_now());
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.owner_id      <= owner;
        req_ch.request_bytes <= bytes;
        do
        begin
            @(negedge clk);
            taken = req_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        predict_grant(op, owner, bytes);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (grants_pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_PAGES_IN_USE)
            pages_cfg = value[PAGES_CFG_W-1:0];
        else
            max_bytes_cfg = value[BYTES_W-1:0];
    endtask

    // Result side: ready is driven at the rising edge, the handshake is
    // sampled at the falling edge where everything is stable.
    initial
    begin
        grant_t g;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= !idle_now();
            @(negedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (grants_pending.size() == 0)
                    report("unexpected item", rsp_ch.start_address, 0);
                else
                begin
                    g = grants_pending.pop_front();
                    if (rsp_ch.ok !== g.ok)
                        report("ok", rsp_ch.ok, g.ok);
                    if (rsp_ch.start_address !== g.start_address)
                        report("start_address", rsp_ch.start_address, g.start_address);
                end
            end
        end
    end

    task automatic test_field_edges();
        send_item(OP_ALLOC, 6'd0, 25'd0);
        send_item(OP_ALLOC, 6'd0, 25'd1);
        send_item(OP_ALLOC, 6'd63, 25'd4096);
        send_item(OP_ALLOC, 6'd1, 25'd4097);
        send_item(OP_ALLOC, 6'd2, 25'd16777216);
        send_item(OP_ALLOC, 6'd3, 25'd16777217);
        send_item(OP_ALLOC, 6'd3, 25'h1FFFFFF);
        send_item(OP_ALLOC, 6'd4, 25'd8191);
        send_item(OP_FREE, 6'd63, 25'h1FFFFFF);
        send_item(OP_FREE, 6'd42, 25'd0);
        send_item(OP_ALLOC, 6'd5, 25'd3000);
        send_item(OP_FREE, 6'd2, 25'd1);
        send_item(OP_ALLOC, 6'd6, 25'd16777216);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_MAX_REQUEST, 25'd0);
        send_item(OP_ALLOC, 6'd7, 25'd1);
        write_reg(CFG_MAX_REQUEST, 25'd1);
        send_item(OP_ALLOC, 6'd7, 25'd1);
        send_item(OP_ALLOC, 6'd7, 25'd2);
        write_reg(CFG_MAX_REQUEST, 25'h1FFFFFF);
        send_item(OP_ALLOC, 6'd8, 25'h1FFFFFF);
        send_item(OP_ALLOC, 6'd8, 25'd16777217);
        write_reg(CFG_PAGES_IN_USE, 25'd0);
        send_item(OP_ALLOC, 6'd9, 25'd1);
        // Shrunk memory: pages held beyond the end stay owned until freed.
        write_reg(CFG_PAGES_IN_USE, 25'd1);
        send_item(OP_ALLOC, 6'd9, 25'd1);
        send_item(OP_ALLOC, 6'd9, 25'd2);
        send_item(OP_FREE, 6'd6, 25'd0);
        write_reg(CFG_PAGES_IN_USE, 25'h3FFF);
        send_item(OP_ALLOC, 6'd10, 25'd16777216);
        write_reg(CFG_PAGES_IN_USE, 25'h1FFC040);
        send_item(OP_ALLOC, 6'd11, 25'd20000);
    endtask

    task automatic random_phase(input int count, input bit with_calm);
        logic [BYTES_W-1:0] bytes;
        int                 pick;
        for (int i = 0; i < count; i++)
        begin
            calm = with_calm && (i >= count / 3) && (i < count / 2);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                bytes = BYTES_W'($urandom_range(1, 16384));
            else if (pick < 82)
                bytes = BYTES_W'($urandom_range(1, 262144));
            else if (pick < 92)
                bytes = BYTES_W'($urandom);
            else
                bytes = BYTES_W'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 12)
                send_item(OP_FREE, OWNER_W'($urandom_range(0, 63)), BYTES_W'($urandom));
            else
                send_item(OP_ALLOC, OWNER_W'($urandom_range(0, 63)), bytes);
        end
        calm = 0;
    endtask

    task automatic test_random_traffic();
        write_reg(CFG_PAGES_IN_USE, 25'd64);
        write_reg(CFG_MAX_REQUEST, 25'd65536);
        random_phase(25, 0);
        write_reg(CFG_PAGES_IN_USE, 25'd8192);
        write_reg(CFG_MAX_REQUEST, 25'd16777216);
        random_phase(50, 1);
    endtask

    initial
    begin
        error_count   = 0;
        cycle_count   = 0;
        calm          = 0;
        pages_cfg     = PAGES_RESET;
        max_bytes_cfg = MAX_REQ_RESET;
        foreach (owner_table[p])
            owner_table[p] = 0;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_PAGES_IN_USE;
        cfg_data             <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.operation     <= OP_ALLOC;
        req_ch.owner_id      <= '0;
        req_ch.request_bytes <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_edges();
        test_register_extremes();
        test_random_traffic();

        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: aligned_page_allocator.f
+incdir+sv
sv/apa_pkg.sv
sv/apa_req_if.sv
sv/apa_rsp_if.sv
sv/apa_datapath.sv
sv/apa_ctrl.sv
sv/aligned_page_allocator.sv
test/aligned_page_allocator_tb.sv
